// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate-cycle implication check on the rising clock, masked during reset
`define SPHX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication check on the rising clock, masked during reset
`define SPHX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sphx_pkg.sv -----
package sphx_pkg;

  localparam int NUM_VOLUMES_DEF = 64;
  localparam int NUM_MOVERS_DEF  = 256;
  localparam int MASK_W          = 64;
  localparam int MASK_IW         = 6;
  localparam int CNT_W           = 9;
  localparam int OLAP_LAT        = 4;
  localparam int IN_DATA_W       = 144;
  localparam int IN_USER_W       = 2;
  localparam int OUT_DATA_W      = 88;

  // input operation codes
  typedef enum logic [1:0] {
    OP_SET_MOV = 2'd0,
    OP_REM_MOV = 2'd1,
    OP_SET_VOL = 2'd2,
    OP_CLR_VOL = 2'd3
  } op_t;

  // classified work for the back end
  typedef enum logic [2:0] {
    K_SET_MOV,
    K_REM_MOV,
    K_SET_VOL,
    K_CLR_VOL,
    K_NOP
  } kind_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        rad;
  } geo_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  mover_id;
    logic [5:0]  volume_id;
    geo_t        geo;
    logic        bnd;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MOV_SCAN,
    B_MOV_DONE,
    B_VOL_SCAN,
    B_OUT
  } bstate_t;

endpackage

// ----- hdl/sphx_front.sv -----
module sphx_front #(
  parameter int NUM_VOLUMES = sphx_pkg::NUM_VOLUMES_DEF,
  parameter int NUM_MOVERS  = sphx_pkg::NUM_MOVERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mover_id, volume_id, center_x, center_y, center_z, sphere_radius, bounded, pad
  input  logic [sphx_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [sphx_pkg::IN_USER_W-1:0]  in_tuser,
  output sphx_pkg::item_t                 q_item,
  output logic                            q_valid,
  input  logic                            q_pop
);
  import sphx_pkg::*;

  logic        swept_r;
  item_t       q_mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  q_cnt_r;
  item_t       cls;
  logic        push;
  op_t         op;

  // swept enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swept_r <= 1'b1;
    end else if (cfg_we) begin
      swept_r <= cfg_wdata;
    end
  end

  // unpack and classify the incoming transaction
  always_comb begin
    op            = op_t'(in_tuser);
    cls.mover_id  = in_tdata[7:0];
    cls.volume_id = in_tdata[13:8];
    cls.geo.cx    = in_tdata[45:14];
    cls.geo.cy    = in_tdata[77:46];
    cls.geo.cz    = in_tdata[109:78];
    cls.geo.rad   = in_tdata[140:110];
    cls.bnd       = in_tdata[141];
    cls.kind      = K_NOP;
    unique case (op)
      OP_SET_MOV: begin
        cls.bnd = in_tdata[141] & swept_r;
        if (int'(cls.mover_id) < NUM_MOVERS) cls.kind = K_SET_MOV;
      end
      OP_REM_MOV: begin
        if (int'(cls.mover_id) < NUM_MOVERS) cls.kind = K_REM_MOV;
      end
      OP_SET_VOL: begin
        if (int'(cls.volume_id) < NUM_VOLUMES) cls.kind = K_SET_VOL;
      end
      OP_CLR_VOL: begin
        if (int'(cls.volume_id) < NUM_VOLUMES) cls.kind = K_CLR_VOL;
      end
      default: cls.kind = K_NOP;
    endcase
  end

  assign in_tready = (q_cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (q_cnt_r != 2'd0);
  assign q_item    = q_mem_r[rp_r];

  // two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      if (push && !q_pop) q_cnt_r <= q_cnt_r + 2'd1;
      else if (!push && q_pop) q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= cls;
  end

`include "assert_macros.svh"
  `SPHX_ASSERT(a_q_bound, q_cnt_r != 2'd3, "queue count out of range")
  `SPHX_ASSERT(a_q_pop, q_pop |-> q_cnt_r != 2'd0, "pop from empty queue")

endmodule

// ----- hdl/sphx_olap.sv -----
module sphx_olap (
  input  logic            clk,
  input  sphx_pkg::geo_t  a,
  input  sphx_pkg::geo_t  b,
  output logic            hit
);
  import sphx_pkg::*;

  function automatic logic [31:0] absd(logic signed [31:0] p, logic signed [31:0] q);
    logic signed [32:0] d;
    d = {p[31], p} - {q[31], q};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  logic [31:0] ax_r, ay_r, az_r, rr_r;
  logic [63:0] sx_r, sy_r, sz_r, rr2_r, rr2b_r;
  logic [65:0] sum_r;
  logic        hit_r;

  // distance components and radius sum, then squares, sum, compare
  always_ff @(posedge clk) begin
    ax_r   <= absd(a.cx, b.cx);
    ay_r   <= absd(a.cy, b.cy);
    az_r   <= absd(a.cz, b.cz);
    rr_r   <= {1'b0, a.rad} + {1'b0, b.rad};
    sx_r   <= ax_r * ax_r;
    sy_r   <= ay_r * ay_r;
    sz_r   <= az_r * az_r;
    rr2_r  <= rr_r * rr_r;
    sum_r  <= 66'(sx_r) + 66'(sy_r) + 66'(sz_r);
    rr2b_r <= rr2_r;
    hit_r  <= (sum_r <= {2'b00, rr2b_r});
  end

  assign hit = hit_r;

endmodule

// ----- hdl/sphx_back.sv -----
module sphx_back #(
  parameter int NUM_VOLUMES = sphx_pkg::NUM_VOLUMES_DEF,
  parameter int NUM_MOVERS  = sphx_pkg::NUM_MOVERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sphx_pkg::item_t                 q_item,
  input  logic                            q_valid,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // exposure_mask, exposed_count, unbounded_count, pad
  output logic [sphx_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sphx_pkg::*;

  localparam int NV = NUM_VOLUMES;
  localparam int NM = NUM_MOVERS;
  localparam int MW = (NM > 1) ? $clog2(NM) : 1;
  localparam int VW = (NV > 1) ? $clog2(NV) : 1;
  localparam int CW = $clog2(((NM > NV) ? NM : NV) + 1);
  localparam int L  = OLAP_LAT;

  bstate_t st_r, st_nxt;
  item_t   cur_r;

  // mover and volume tables
  geo_t              mov_geo_mem  [NM];
  logic [MASK_W-1:0] mov_mask_mem [NM];
  geo_t              vol_geo_mem  [NV];
  geo_t              mov_geo_rd_r, vol_geo_rd_r;
  logic [MASK_W-1:0] mov_mask_rd_r;
  logic [NM-1:0]     mov_trk_r, mov_unb_r;
  logic [NV-1:0]     vol_live_r, vol_bnd_r;
  logic [CNT_W-1:0]  tot_r, n_r;
  logic [MASK_W-1:0] nmask_r;

  // scan sequencing and side pipeline
  logic [CW-1:0]     cnt_r, limit;
  logic [L:0]        vld_sh_r;
  logic [CW-1:0]     idx_sh_r  [L+1];
  logic [L:0]        trk_sh_r, unb_sh_r, vlive_sh_r, vbnd_sh_r;
  logic [MASK_W-1:0] mask_sh_r [L+1];

  logic              issue, scan_end, out_load, mask_we, olap_hit, hit_raw, vhit;
  logic [MW-1:0]     q_mid, cur_mid, mask_wa;
  logic [VW-1:0]     q_vid;
  logic [MASK_W-1:0] vbit, mask_wd;
  geo_t              op_a, op_b;

  logic              out_vld_r;
  logic [MASK_W-1:0] out_mask_r;
  logic [CNT_W-1:0]  out_cnt_r, out_unb_r;

  assign q_mid   = MW'(q_item.mover_id);
  assign q_vid   = VW'(q_item.volume_id);
  assign cur_mid = MW'(cur_r.mover_id);
  assign vbit    = MASK_W'(1) << MASK_IW'(cur_r.volume_id);
  assign limit   = (st_r == B_MOV_SCAN) ? CW'(NV) : CW'(NM);
  assign scan_end = (cnt_r == limit) && (vld_sh_r == '0);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            K_SET_MOV:            st_nxt = q_item.bnd ? B_MOV_SCAN : B_MOV_DONE;
            K_SET_VOL, K_CLR_VOL: st_nxt = B_VOL_SCAN;
            default:              st_nxt = B_OUT;
          endcase
        end
      end
      B_MOV_SCAN: if (scan_end) st_nxt = B_MOV_DONE;
      B_MOV_DONE: st_nxt = B_OUT;
      B_VOL_SCAN: if (scan_end) st_nxt = B_OUT;
      B_OUT:      if (out_load) st_nxt = B_IDLE;
      default:    st_nxt = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      B_IDLE:                 q_pop = q_valid;
      B_MOV_SCAN, B_VOL_SCAN: issue = (cnt_r < limit);
      B_OUT:                  out_load = !out_vld_r || out_tready;
      default:                q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= B_IDLE;
    else        st_r <= st_nxt;
  end

  // overlap operands: the held item against the table entry being scanned
  assign op_a = (st_r == B_MOV_SCAN) ? cur_r.geo : mov_geo_rd_r;
  assign op_b = (st_r == B_MOV_SCAN) ? vol_geo_rd_r : cur_r.geo;

  sphx_olap u_olap (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .hit (olap_hit)
  );

  // an unbounded volume exposes to every bounded mover
  assign hit_raw = !((st_r == B_MOV_SCAN) ? vbnd_sh_r[L] : cur_r.bnd) || olap_hit;
  assign vhit    = (cur_r.kind == K_SET_VOL) && !unb_sh_r[L] && hit_raw;

  // mask write port: whole mask for a set mover (after its scan if bounded), one bit per tracked mover in a volume scan
  always_comb begin
    mask_we = 1'b0;
    mask_wa = cur_mid;
    mask_wd = nmask_r;
    if (st_r == B_MOV_DONE) begin
      mask_we = 1'b1;
    end else if (st_r == B_VOL_SCAN && vld_sh_r[L] && trk_sh_r[L]) begin
      mask_we = 1'b1;
      mask_wa = idx_sh_r[L][MW-1:0];
      mask_wd = (mask_sh_r[L] & ~vbit) | (vhit ? vbit : '0);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && q_valid && q_item.kind == K_SET_MOV) mov_geo_mem[q_mid] <= q_item.geo;
    if (mask_we) mov_mask_mem[mask_wa] <= mask_wd;
    if (issue) begin
      mov_geo_rd_r  <= mov_geo_mem[cnt_r[MW-1:0]];
      mov_mask_rd_r <= mov_mask_mem[cnt_r[MW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && q_valid && q_item.kind == K_SET_VOL) vol_geo_mem[q_vid] <= q_item.geo;
    if (issue) vol_geo_rd_r <= vol_geo_mem[cnt_r[VW-1:0]];
  end

  // flags, totals and scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mov_trk_r  <= '0;
      mov_unb_r  <= '0;
      vol_live_r <= '0;
      vol_bnd_r  <= '0;
      tot_r      <= '0;
      cnt_r      <= '0;
      vld_sh_r   <= '0;
    end else begin
      vld_sh_r <= {vld_sh_r[L-1:0], issue};
      if (issue) cnt_r <= cnt_r + CW'(1);
      if (q_pop) begin
        cnt_r <= '0;
        case (q_item.kind)
          K_SET_MOV: begin
            if (!q_item.bnd && !(mov_trk_r[q_mid] && mov_unb_r[q_mid])) tot_r <= tot_r + 1'b1;
            else if (q_item.bnd && mov_trk_r[q_mid] && mov_unb_r[q_mid]) tot_r <= tot_r - 1'b1;
            mov_trk_r[q_mid] <= 1'b1;
            mov_unb_r[q_mid] <= !q_item.bnd;
          end
          K_REM_MOV: begin
            if (mov_trk_r[q_mid] && mov_unb_r[q_mid] && tot_r != '0) tot_r <= tot_r - 1'b1;
            mov_trk_r[q_mid] <= 1'b0;
            mov_unb_r[q_mid] <= 1'b0;
          end
          K_SET_VOL: begin
            vol_live_r[q_vid] <= 1'b1;
            vol_bnd_r[q_vid]  <= q_item.bnd;
          end
          K_CLR_VOL: begin
            vol_live_r[q_vid] <= 1'b0;
            vol_bnd_r[q_vid]  <= 1'b0;
          end
          default: tot_r <= tot_r;
        endcase
      end
    end
  end

  // side information travelling beside the overlap pipeline
  always_ff @(posedge clk) begin
    idx_sh_r[0]   <= cnt_r;
    trk_sh_r[0]   <= mov_trk_r[cnt_r[MW-1:0]];
    unb_sh_r[0]   <= mov_unb_r[cnt_r[MW-1:0]];
    vlive_sh_r[0] <= vol_live_r[cnt_r[VW-1:0]];
    vbnd_sh_r[0]  <= vol_bnd_r[cnt_r[VW-1:0]];
    mask_sh_r[0]  <= '0;
    mask_sh_r[1]  <= mov_mask_rd_r;
    for (int k = 1; k <= L; k++) begin
      idx_sh_r[k]   <= idx_sh_r[k-1];
      trk_sh_r[k]   <= trk_sh_r[k-1];
      unb_sh_r[k]   <= unb_sh_r[k-1];
      vlive_sh_r[k] <= vlive_sh_r[k-1];
      vbnd_sh_r[k]  <= vbnd_sh_r[k-1];
    end
    for (int k = 2; k <= L; k++) mask_sh_r[k] <= mask_sh_r[k-1];
  end

  // held item, new mover mask and hit count
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r   <= q_item;
      nmask_r <= '0;
      n_r     <= '0;
    end else if (vld_sh_r[L]) begin
      if (st_r == B_MOV_SCAN && vlive_sh_r[L] && hit_raw)
        nmask_r[MASK_IW'(idx_sh_r[L])] <= 1'b1;
      if (st_r == B_VOL_SCAN && trk_sh_r[L] && vhit)
        n_r <= n_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mask_r <= nmask_r;
      out_cnt_r  <= n_r;
      out_unb_r  <= tot_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_unb_r, out_cnt_r, out_mask_r};

`include "assert_macros.svh"
  `SPHX_ASSERT(a_drained, (st_r == B_MOV_DONE) |-> (vld_sh_r == '0), "scan left in flight")
  `SPHX_ASSERT(a_unb_tot, tot_r <= 9'd256, "unbounded total beyond mover slots")
  `SPHX_ASSERT_NEXT(a_out_load, out_load, out_vld_r, "result not presented after load")

endmodule

// ----- hdl/sphere_exposure_tracker_core.sv -----
// Sphere exposure tracker.
// Input channel in_*: one transaction per operation, op in in_tuser, fields in in_tdata.
//   Bounded set mover rescans all volumes, set or clear volume rescans all mover slots.
// Result channel out_*: exactly one transaction per input transaction, in order.
// Configuration: cfg_we writes cfg_wdata into the swept enable (1 after reset);
//   write only while no operation is in progress.
//   Other operations, including an unbounded set mover, run no scan.
// The scan reads one table entry per cycle into a four-stage overlap pipeline;
// the back end starts no new operation until the current result is loaded, and a
// two-entry queue takes further transactions meanwhile.
// Reset (rst_n low, synchronous) empties all tables, counts and the queue.
// A stalled receiver holds the result register; the next queued operation
// still runs its scan and then waits until the result register is free.
module sphere_exposure_tracker_core #(
  parameter int NUM_VOLUMES = sphx_pkg::NUM_VOLUMES_DEF,
  parameter int NUM_MOVERS  = sphx_pkg::NUM_MOVERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mover_id, volume_id, center_x, center_y, center_z, sphere_radius, bounded, pad
  input  logic [sphx_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [sphx_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // exposure_mask, exposed_count, unbounded_count, pad
  output logic [sphx_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sphx_pkg::*;

  item_t q_item;
  logic  q_valid, q_pop;

  sphx_front #(
    .NUM_VOLUMES (NUM_VOLUMES),
    .NUM_MOVERS  (NUM_MOVERS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  sphx_back #(
    .NUM_VOLUMES (NUM_VOLUMES),
    .NUM_MOVERS  (NUM_MOVERS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import sphx_pkg::*;

  // one expected result transaction
  typedef struct {
    logic [63:0] mask;
    logic [8:0]  count;
    logic [8:0]  unb;
  } exposure_result_t;

  // exposure tracker mirror and result check
  class exposure_scoreboard;
    logic signed [31:0] vol_x[64], vol_y[64], vol_z[64];
    logic [30:0]        vol_r[64];
    bit                 vol_live[64], vol_bnd[64];
    int                 vol_hits[64];
    logic signed [31:0] mov_x[256], mov_y[256], mov_z[256];
    logic [30:0]        mov_r[256];
    bit                 mov_tracked[256], mov_unb[256];
    logic [63:0]        mov_bits[256];
    int                 unb_total;
    bit                 swept;
    exposure_result_t   pending_results[$];
    int                 errors;

    function new();
      for (int s = 0; s < 64; s++) begin
        vol_live[s] = 0; vol_bnd[s] = 0; vol_hits[s] = 0;
      end
      for (int m = 0; m < 256; m++) begin
        mov_tracked[m] = 0; mov_unb[m] = 0; mov_bits[m] = '0;
      end
      unb_total = 0;
      swept = 1;
      errors = 0;
    endfunction

    function logic [69:0] sq_dist(logic signed [31:0] a, logic signed [31:0] b);
      longint      d;
      logic [69:0] u;
      d = longint'(a) - longint'(b);
      u = (d < 0) ? 70'(-d) : 70'(d);
      return u * u;
    endfunction

    // exact sphere overlap, unbounded volume hits everything
    function bit touches(int s, int m);
      logic [69:0] dsq, rr;
      if (!vol_bnd[s]) return 1;
      dsq = sq_dist(mov_x[m], vol_x[s]) + sq_dist(mov_y[m], vol_y[s])
          + sq_dist(mov_z[m], vol_z[s]);
      rr = 70'(mov_r[m]) + 70'(vol_r[s]);
      return dsq <= rr * rr;
    endfunction

    function logic [8:0] sat9(int v);
      return (v > 511) ? 9'd511 : 9'(v);
    endfunction

    function void drop_mover(int m);
      for (int s = 0; s < 64; s++) if (mov_bits[m][s]) vol_hits[s]--;
      mov_bits[m] = '0;
    endfunction

    // apply one accepted operation and queue its result
    function void note_input(op_t op, int mid, int vid, logic signed [31:0] cx,
                             logic signed [31:0] cy, logic signed [31:0] cz,
                             logic [30:0] rad, bit bnd);
      exposure_result_t r;
      bit               unb, was;
      int               n;
      r.mask = '0;
      r.count = '0;
      case (op)
        OP_SET_MOV: begin
          was = mov_tracked[mid] && mov_unb[mid];
          unb = !(swept && bnd);
          mov_x[mid] = cx; mov_y[mid] = cy; mov_z[mid] = cz; mov_r[mid] = rad;
          mov_tracked[mid] = 1;
          mov_unb[mid] = unb;
          if (unb && !was) unb_total++;
          else if (!unb && was) unb_total--;
          drop_mover(mid);
          if (!unb) begin
            for (int s = 0; s < 64; s++) begin
              if (vol_live[s] && touches(s, mid)) begin
                mov_bits[mid][s] = 1;
                vol_hits[s]++;
              end
            end
          end
          r.mask = mov_bits[mid];
        end
        OP_REM_MOV: begin
          if (mov_tracked[mid]) begin
            drop_mover(mid);
            if (mov_unb[mid] && unb_total > 0) unb_total--;
            mov_tracked[mid] = 0;
            mov_unb[mid] = 0;
          end
        end
        default: begin
          if (op == OP_SET_VOL) begin
            vol_x[vid] = cx; vol_y[vid] = cy; vol_z[vid] = cz; vol_r[vid] = rad;
            vol_live[vid] = 1;
            vol_bnd[vid] = bnd;
          end else begin
            vol_live[vid] = 0;
            vol_bnd[vid] = 0;
          end
          // rescan every tracked mover against this volume
          n = 0;
          for (int m = 0; m < 256; m++) begin
            if (!mov_tracked[m]) continue;
            if (vol_live[vid] && !mov_unb[m] && touches(vid, m)) begin
              mov_bits[m][vid] = 1;
              n++;
            end else begin
              mov_bits[m][vid] = 0;
            end
          end
          vol_hits[vid] = n;
          r.count = sat9(n);
        end
      endcase
      r.unb = sat9(unb_total);
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [95:0] got, logic [95:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      exposure_result_t e;
      if (pending_results.size() == 0) begin
        report("unexpected transaction", 96'(d), 0);
        return;
      end
      e = pending_results.pop_front();
      if (d[63:0] !== e.mask) report("exposure_mask", 96'(d[63:0]), 96'(e.mask));
      if (d[72:64] !== e.count) report("exposed_count", 96'(d[72:64]), 96'(e.count));
      if (d[81:73] !== e.unb) report("unbounded_count", 96'(d[81:73]), 96'(e.unb));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  exposure_scoreboard sb = new();
  int                 items_sent = 0;
  int                 results_seen = 0;

  sphere_exposure_tracker_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // offer one operation, with an occasional gap before it
  task send_op(op_t op, int mid, int vid, logic signed [31:0] cx,
               logic signed [31:0] cy, logic signed [31:0] cz, logic [30:0] rad, bit bnd);
    @(negedge clk);
    if (!(items_sent >= 1000 && items_sent < 1300) && $urandom_range(99) < 14) begin
      in_tvalid = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = op;
    in_tdata = {2'b00, bnd, rad, cz, cy, cx, 6'(vid), 8'(mid)};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, mid, vid, cx, cy, cz, rad, bnd);
    items_sent++;
  endtask

  function logic signed [31:0] pick_coord(bit wide);
    return wide ? $urandom : 32'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
  endfunction

  // random operation, mostly on a small working set so overlaps happen
  task send_random();
    op_t op;
    bit  wide;
    int  mid, vid;
    op = op_t'($urandom_range(3));
    wide = ($urandom_range(99) < 20);
    mid = ($urandom_range(99) < 70) ? $urandom_range(31) : $urandom_range(255);
    vid = ($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(63);
    send_op(op, mid, vid, pick_coord(wide), pick_coord(wide), pick_coord(wide),
            wide ? 31'($urandom) : 31'($urandom_range(65536 * 12)),
            $urandom_range(99) < 80);
  endtask

  task wait_idle();
    @(negedge clk);
    in_tvalid = 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_swept(bit value);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
    sb.swept = value;
  endtask

  // main sequence
  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, each operation, corner cases
    send_op(OP_REM_MOV, 7, 0, 0, 0, 0, 0, 1);
    send_op(OP_CLR_VOL, 5, 5, 0, 0, 0, 0, 0);
    send_op(OP_SET_VOL, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_SET_VOL, 0, 63, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            31'h7fff_ffff, 1);
    send_op(OP_SET_MOV, 255, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            31'h7fff_ffff, 1);
    send_op(OP_SET_MOV, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1);
    send_op(OP_SET_VOL, 0, 1, 32'h0001_0000, 0, 0, 31'h0000_8000, 1);
    send_op(OP_SET_MOV, 1, 0, 0, 0, 0, 31'h0000_8000, 1);
    send_op(OP_SET_MOV, 2, 0, 32'h0002_0000, 0, 0, 31'h0000_7fff, 1);
    send_op(OP_SET_MOV, 3, 0, 0, 0, 0, 0, 0);
    send_op(OP_SET_MOV, 3, 0, 0, 0, 0, 31'h10000, 1);
    send_op(OP_SET_MOV, 1, 0, 0, 0, 0, 0, 0);
    send_op(OP_SET_VOL, 0, 1, 0, 32'hffff_0000, 0, 31'h1000_0000, 1);
    send_op(OP_REM_MOV, 1, 0, 0, 0, 0, 0, 0);
    send_op(OP_REM_MOV, 2, 0, 0, 0, 0, 0, 0);
    send_op(OP_REM_MOV, 2, 0, 0, 0, 0, 0, 0);
    send_op(OP_CLR_VOL, 0, 63, 0, 0, 0, 0, 0);
    send_op(OP_CLR_VOL, 0, 0, 0, 0, 0, 0, 1);
    wait_idle();

    // random phases across both register settings
    repeat (700) send_random();
    wait_idle();
    write_swept(0);
    repeat (300) send_random();
    wait_idle();
    write_swept(1);
    repeat (900) send_random();
    wait_idle();
    repeat (300) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result receiver readiness, with one long hold-off
  initial begin
    bit held;
    held = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 300) begin
        held = 1;
        out_tready = 0;
        repeat (3000) @(negedge clk);
      end
      if (results_seen >= 800 && results_seen < 1100) out_tready = 1;
      else out_tready = ($urandom_range(99) >= 14);
    end
  end

  // result check on each accepted transaction
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        results_seen++;
      end
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
